// File: src/sorted_matrix_search_defines.svh
// Assertion macros shared by the sorted matrix search block.
`ifndef SORTED_MATRIX_SEARCH_DEFINES_SVH
`define SORTED_MATRIX_SEARCH_DEFINES_SVH

// Same-cycle implication, sampled on clk and switched off during reset.
`define SMX_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("sorted matrix search: same-cycle check failed");

// Next-cycle implication, sampled on clk and switched off during reset.
`define SMX_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("sorted matrix search: next-cycle check failed");

`endif

// File: src/smx_pkg.sv
package smx_pkg;

  localparam int DATA_W = 32;
  localparam int IDX_W  = 4;

  typedef logic signed [DATA_W-1:0] data_t;
  typedef logic [IDX_W-1:0]         idx_t;

  localparam logic OP_WRITE  = 1'b0;
  localparam logic OP_SEARCH = 1'b1;

endpackage

// File: src/smx_ram.sv
module smx_ram #(
  parameter int  WIDTH = 32,
  parameter int  DEPTH = 256,
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: src/sorted_matrix_search.sv
// Sorted matrix search. The block keeps a NUM_ROWS x NUM_COLS matrix of
// signed 32-bit entries in a single on-chip RAM and answers searches on it.
// A write transaction (opcode 0) stores item_value at row_index, col_index
// and gives no result; writes outside the matrix are dropped. A search
// transaction (opcode 1) walks the matrix from its top-right corner: an
// equal entry ends the walk, a smaller one moves it down a row, and a
// larger one starts a binary search of the row to the left, after which the
// walk either reports the hit or steps one column left; the walk ends with a
// miss when it would leave the bottom row or the first column. Every search
// gives exactly one result transaction with found, found_row and found_col
// (row and column are zero when nothing was found). All reads go through the
// one RAM read port and one shared signed comparator, and each read has an
// address state followed by a compare state. A search makes at most
// NUM_ROWS + NUM_COLS - 1 staircase reads, plus ceil(log2(c + 1)) reads for
// the row search left of each column c that the walk leaves, which for the
// default 16 x 16 matrix is at worst 31 + 49 = 80 reads; a finished result
// may also wait in the done state for the output register to free up. The
// block takes no new transaction while a search runs, but it does accept one
// while an earlier result still waits on the output. Entries must be written
// before any search can read them; the RAM is not cleared by reset.
`include "sorted_matrix_search_defines.svh"

module sorted_matrix_search #(
  parameter int NUM_ROWS = 16,
  parameter int NUM_COLS = 16
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          item_valid,
  output logic          item_ready,
  input  logic          opcode,
  input  smx_pkg::idx_t row_index,
  input  smx_pkg::idx_t col_index,
  input  smx_pkg::data_t item_value,
  output logic          result_valid,
  input  logic          result_ready,
  output logic          found,
  output smx_pkg::idx_t found_row,
  output smx_pkg::idx_t found_col
);

  import smx_pkg::*;

  localparam int ROW_W  = (NUM_ROWS > 1) ? $clog2(NUM_ROWS) : 1;
  localparam int COL_W  = (NUM_COLS > 1) ? $clog2(NUM_COLS) : 1;
  localparam int DEPTH  = NUM_ROWS * NUM_COLS;
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  // Sequencer state codes.
  localparam logic [2:0] ST_IDLE     = 3'd0;
  localparam logic [2:0] ST_STAIR_RD = 3'd1;
  localparam logic [2:0] ST_STAIR_CM = 3'd2;
  localparam logic [2:0] ST_BS_RD    = 3'd3;
  localparam logic [2:0] ST_BS_CM    = 3'd4;
  localparam logic [2:0] ST_DONE     = 3'd5;

  logic [2:0]       state, state_next;
  logic [ROW_W-1:0] r, r_next;
  logic [COL_W-1:0] c, c_next;
  logic [COL_W-1:0] lo, lo_next;
  logic [COL_W-1:0] hip1, hip1_next;
  logic             hit, hit_next;
  data_t            target;

  logic [COL_W:0]   mid_sum;
  logic [COL_W-1:0] mid;
  logic [COL_W-1:0] rd_col;
  logic [ADDR_W-1:0] raddr, waddr;
  logic             we;
  logic             wr_in_range;
  logic [DATA_W-1:0] rdata;
  data_t            rd_entry;
  logic             cell_eq, cell_lt;
  logic             accept, out_free;

  function automatic logic [ADDR_W-1:0] cell_addr(input logic [ADDR_W-1:0] row,
                                                  input logic [ADDR_W-1:0] col);
    return row * ADDR_W'(NUM_COLS) + col;
  endfunction

  // Handshakes. The output register frees up as soon as its result is taken.
  assign item_ready = (state == ST_IDLE);
  assign accept     = item_valid && item_ready;
  assign out_free   = !result_valid || result_ready;

  // Write path: straight into the RAM.
  assign wr_in_range = ({5'b0, row_index} < 9'(NUM_ROWS)) &&
                       ({5'b0, col_index} < 9'(NUM_COLS));
  assign we    = accept && (opcode == OP_WRITE) && wr_in_range;
  assign waddr = cell_addr(ADDR_W'(row_index), ADDR_W'(col_index));

  // Midpoint of the half-open binary-search range [lo, hip1); hip1 > lo here.
  assign mid_sum = {1'b0, lo} + {1'b0, hip1} - (COL_W+1)'(1);
  assign mid     = mid_sum[COL_W:1];

  assign rd_col = (state == ST_BS_RD) ? mid : c;
  assign raddr  = cell_addr(ADDR_W'(r), ADDR_W'(rd_col));

  smx_ram #(
    .WIDTH (DATA_W),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (item_value),
    .raddr (raddr),
    .rdata (rdata)
  );

  // The one shared comparator, used by both the staircase and the row search.
  assign rd_entry = data_t'(rdata);
  assign cell_eq  = (rd_entry == target);
  assign cell_lt  = (rd_entry < target);

  always_comb begin
    state_next = state;
    r_next     = r;
    c_next     = c;
    lo_next    = lo;
    hip1_next  = hip1;
    hit_next   = hit;
    unique case (state)
      ST_IDLE: begin
        if (accept && (opcode == OP_SEARCH)) begin
          r_next     = '0;
          c_next     = COL_W'(NUM_COLS - 1);
          hit_next   = 1'b0;
          state_next = ST_STAIR_RD;
        end
      end
      ST_STAIR_RD: begin
        state_next = ST_STAIR_CM;
      end
      ST_STAIR_CM: begin
        if (cell_eq) begin
          hit_next   = 1'b1;
          state_next = ST_DONE;
        end else if (cell_lt) begin
          if (r == ROW_W'(NUM_ROWS - 1)) begin
            state_next = ST_DONE;
          end else begin
            r_next     = r + ROW_W'(1);
            state_next = ST_STAIR_RD;
          end
        end else if (c == '0) begin
          // Nothing left of the first column: the walk falls off the matrix.
          state_next = ST_DONE;
        end else begin
          lo_next    = '0;
          hip1_next  = c;
          state_next = ST_BS_RD;
        end
      end
      ST_BS_RD: begin
        state_next = ST_BS_CM;
      end
      ST_BS_CM: begin
        if (cell_eq) begin
          hit_next   = 1'b1;
          c_next     = mid;
          state_next = ST_DONE;
        end else begin
          if (cell_lt) begin
            lo_next = mid + COL_W'(1);
          end else begin
            hip1_next = mid;
          end
          if (lo_next >= hip1_next) begin
            if (c == '0) begin
              state_next = ST_DONE;
            end else begin
              c_next     = c - COL_W'(1);
              state_next = ST_STAIR_RD;
            end
          end else begin
            state_next = ST_BS_RD;
          end
        end
      end
      ST_DONE: begin
        if (out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      result_valid <= 1'b0;
    end else begin
      state <= state_next;
      if ((state == ST_DONE) && out_free) begin
        result_valid <= 1'b1;
      end else if (result_ready) begin
        result_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    r    <= r_next;
    c    <= c_next;
    lo   <= lo_next;
    hip1 <= hip1_next;
    hit  <= hit_next;
    if (accept) begin
      target <= item_value;
    end
    if ((state == ST_DONE) && out_free) begin
      found     <= hit;
      found_row <= hit ? IDX_W'(r) : '0;
      found_col <= hit ? IDX_W'(c) : '0;
    end
  end

  // A row search only ever reads inside a non-empty range.
  `SMX_ASSERT_NOW(a_bs_range, (state == ST_BS_CM), (hip1 > lo))
  // An accepted search always starts the staircase from the top row.
  `SMX_ASSERT_NEXT(a_search_start, (accept && (opcode == OP_SEARCH)),
                   ((state == ST_STAIR_RD) && (r == '0)))
  // A miss is reported with a zero position.
  `SMX_ASSERT_NOW(a_miss_zero, (result_valid && !found),
                  ((found_row == '0) && (found_col == '0)))

endmodule

// File: dv/sorted_matrix_search_checker.sv
module sorted_matrix_search_checker #(
  parameter int NUM_ROWS = 16,
  parameter int NUM_COLS = 16
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           item_valid,
  input  logic           item_ready,
  input  logic           opcode,
  input  smx_pkg::idx_t  row_index,
  input  smx_pkg::idx_t  col_index,
  input  smx_pkg::data_t item_value,
  input  logic           result_valid,
  input  logic           result_ready,
  input  logic           found,
  input  smx_pkg::idx_t  found_row,
  input  smx_pkg::idx_t  found_col,
  output int             fail_count,
  output int             pending
);
  import smx_pkg::*;

  typedef struct packed {
    data_t target;
    logic  hit;
    idx_t  row;
    idx_t  col;
  } lookup_t;

  data_t   cells [NUM_ROWS][NUM_COLS];
  lookup_t answers_due[$];
  lookup_t due;
  int      mismatches = 0;

  // Staircase walk from the top-right corner, with a binary search of the
  // row to the left whenever the current cell is larger than the target.
  function automatic lookup_t staircase_lookup(data_t target);
    lookup_t res;
    int      r;
    int      c;
    int      lo;
    int      hi;
    int      mid;
    res        = '0;
    res.target = target;
    r          = 0;
    c          = NUM_COLS - 1;
    while (r < NUM_ROWS && c >= 0) begin
      if (cells[r][c] == target) begin
        res.hit = 1'b1;
        res.row = idx_t'(r);
        res.col = idx_t'(c);
        return res;
      end else if (cells[r][c] < target) begin
        r++;
      end else begin
        lo = 0;
        hi = c - 1;
        while (lo <= hi) begin
          mid = lo + (hi - lo) / 2;
          if (cells[r][mid] == target) begin
            res.hit = 1'b1;
            res.row = idx_t'(r);
            res.col = idx_t'(mid);
            return res;
          end else if (cells[r][mid] < target) begin
            lo = mid + 1;
          end else begin
            hi = mid - 1;
          end
        end
        c--;
      end
    end
    return res;
  endfunction

  task automatic note_failure(string what);
    if (mismatches < 10) begin
      $display("[%0t] search check error: %s", $realtime, what);
    end
    mismatches++;
  endtask

  always @(posedge clk) begin
    if (!rst) begin
      // Results are taken first: a result at this edge can only belong to a
      // search accepted at an earlier edge.
      if (result_valid && result_ready) begin
        if (answers_due.size() == 0) begin
          note_failure($sformatf("result found=%0d row=%0d col=%0d with no search waiting",
                                 found, found_row, found_col));
        end else begin
          due = answers_due.pop_front();
          if (found !== due.hit || found_row !== due.row || found_col !== due.col) begin
            note_failure($sformatf(
              "target %0d: expected found=%0d row=%0d col=%0d, got found=%0d row=%0d col=%0d",
              due.target, due.hit, due.row, due.col, found, found_row, found_col));
          end
        end
      end
      if (item_valid && item_ready) begin
        if (opcode == OP_WRITE) begin
          if (row_index < NUM_ROWS && col_index < NUM_COLS) begin
            cells[row_index][col_index] = item_value;
          end
        end else begin
          answers_due.push_back(staircase_lookup(item_value));
        end
      end
    end
    pending    <= answers_due.size();
    fail_count <= mismatches;
  end

endmodule

// File: dv/sorted_matrix_search_tb.sv
// Top of the sorted matrix search bench. This module only makes stimulus and
// gives the verdict; the checker beside the block watches both channels,
// keeps its own copy of the matrix and predicts every search result.
module sorted_matrix_search_tb;
  import smx_pkg::*;

  localparam int    ROWS         = 16;
  localparam int    COLS         = 16;
  localparam int    CLK_PERIOD   = 12;
  localparam int    RESET_CYCLES = 5;
  // A search makes at most 80 reads, so this comfortably covers the
  // tail of the last one and any write still being absorbed.
  localparam int    DRAIN_CYCLES = 300;
  localparam int    HOLD_CYCLES  = 800;
  localparam data_t VALUE_MIN    = data_t'(32'h8000_0000);
  localparam data_t VALUE_MAX    = data_t'(32'h7fff_ffff);

  logic  clk;
  logic  rst          = 1'b1;
  logic  item_valid   = 1'b0;
  logic  opcode       = OP_WRITE;
  idx_t  row_index    = '0;
  idx_t  col_index    = '0;
  data_t item_value   = '0;
  logic  result_ready = 1'b0;

  logic  item_ready;
  logic  result_valid;
  logic  found;
  idx_t  found_row;
  idx_t  found_col;
  int    fail_count;
  int    pending;

  // Idle percentages of the two sides, changed between phases.
  int    tx_idle_pct = 36;
  int    rx_idle_pct = 54;

  // Long receiver hold-off, requested once by the stimulus and counted out
  // by the receiver process itself.
  logic  hold_req    = 1'b0;
  logic  hold_taken  = 1'b0;
  int    hold_left   = 0;

  // What the stimulus believes is stored, used to pick targets that hit.
  data_t grid [ROWS][COLS];

  sorted_matrix_search #(
    .NUM_ROWS(ROWS),
    .NUM_COLS(COLS)
  ) DUT (
    .clk         (clk),
    .rst         (rst),
    .item_valid  (item_valid),
    .item_ready  (item_ready),
    .opcode      (opcode),
    .row_index   (row_index),
    .col_index   (col_index),
    .item_value  (item_value),
    .result_valid(result_valid),
    .result_ready(result_ready),
    .found       (found),
    .found_row   (found_row),
    .found_col   (found_col)
  );

  sorted_matrix_search_checker #(
    .NUM_ROWS(ROWS),
    .NUM_COLS(COLS)
  ) search_monitor (
    .clk         (clk),
    .rst         (rst),
    .item_valid  (item_valid),
    .item_ready  (item_ready),
    .opcode      (opcode),
    .row_index   (row_index),
    .col_index   (col_index),
    .item_value  (item_value),
    .result_valid(result_valid),
    .result_ready(result_ready),
    .found       (found),
    .found_row   (found_row),
    .found_col   (found_col),
    .fail_count  (fail_count),
    .pending     (pending)
  );

  initial begin
    clk = 1'b0;
    forever #(CLK_PERIOD / 2) clk = ~clk;
  end

  // Hard stop in case the block hangs or a result never arrives.
  initial begin
    #(CLK_PERIOD * 1_000_000);
    $display("Simulation FAILED");
    $finish;
  end

  // Result side. Outside the single long hold-off, ready is drawn afresh
  // every cycle according to the current idle percentage.
  always @(posedge clk) begin
    if (rst) begin
      result_ready <= 1'b0;
    end else if (hold_left != 0) begin
      result_ready <= 1'b0;
      hold_left    <= hold_left - 1;
    end else if (hold_req && !hold_taken) begin
      hold_taken   <= 1'b1;
      hold_left    <= HOLD_CYCLES;
      result_ready <= 1'b0;
    end else begin
      result_ready <= ($urandom_range(99) >= rx_idle_pct);
    end
  end

  // Offers one transaction and returns at the edge where it is accepted.
  // Valid is only dropped when an idle gap is drawn, so back-to-back
  // transactions keep it high throughout.
  task automatic send_item(input logic op, input idx_t r, input idx_t c, input data_t v);
    if ($urandom_range(99) < tx_idle_pct) begin
      item_valid <= 1'b0;
      @(posedge clk);
      while ($urandom_range(99) < tx_idle_pct) @(posedge clk);
    end
    item_valid <= 1'b1;
    opcode     <= op;
    row_index  <= r;
    col_index  <= c;
    item_value <= v;
    @(posedge clk);
    while (!item_ready) @(posedge clk);
    if (op == OP_WRITE) begin
      grid[r][c] = v;
    end
  endtask

  // Row and column are don't-care for a search, so they are randomised to
  // show that the block really ignores them.
  task automatic search_for(input data_t v);
    send_item(OP_SEARCH, idx_t'($urandom), idx_t'($urandom), v);
  endtask

  // Stops offering and waits until the checker has seen every result. The
  // first edge lets the count settle after the last accepted search.
  task automatic drain_results();
    item_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  function automatic data_t value_between(longint lo, longint hi);
    longint unsigned span;
    longint unsigned offset;
    span   = longint'(hi - lo);
    offset = {$urandom, $urandom} % (span + 1);
    return data_t'(lo + longint'(offset));
  endfunction

  // Nudges a value upwards, for up to 64 tries, until it is nowhere in the
  // matrix, so that the search that follows should report a miss.
  function automatic data_t absent_near(data_t v);
    data_t cand;
    logic  seen;
    cand = v;
    for (int tries = 0; tries < 64; tries++) begin
      cand = cand + 1;
      seen = 1'b0;
      for (int r = 0; r < ROWS; r++) begin
        for (int c = 0; c < COLS; c++) begin
          if (grid[r][c] == cand) seen = 1'b1;
        end
      end
      if (!seen) return cand;
    end
    return cand;
  endfunction

  // Builds a matrix sorted along rows and columns, each cell at least the
  // larger of its upper and left neighbours, and writes it in a shuffled
  // order. One step in eight is zero, which gives duplicate entries. With
  // pin_extremes the corners carry the most negative and most positive
  // values; the step bound keeps every path within 32 bits.
  task automatic fill_sorted(input longint start, input int max_step, input logic pin_extremes);
    longint plan [ROWS][COLS];
    int     order [ROWS*COLS];
    longint base;
    int     j;
    int     tmp;
    for (int r = 0; r < ROWS; r++) begin
      for (int c = 0; c < COLS; c++) begin
        if (r == 0 && c == 0) begin
          plan[r][c] = start;
        end else begin
          if (r == 0) base = plan[r][c-1];
          else if (c == 0) base = plan[r-1][c];
          else base = (plan[r-1][c] > plan[r][c-1]) ? plan[r-1][c] : plan[r][c-1];
          if ($urandom_range(7) == 0) plan[r][c] = base;
          else plan[r][c] = base + $urandom_range(max_step);
        end
      end
    end
    if (pin_extremes) begin
      plan[0][0]           = longint'(VALUE_MIN);
      plan[ROWS-1][COLS-1] = longint'(VALUE_MAX);
    end
    for (int i = 0; i < ROWS * COLS; i++) order[i] = i;
    for (int i = ROWS * COLS - 1; i > 0; i--) begin
      j        = $urandom_range(i);
      tmp      = order[i];
      order[i] = order[j];
      order[j] = tmp;
    end
    for (int i = 0; i < ROWS * COLS; i++) begin
      send_item(OP_WRITE, idx_t'(order[i] / COLS), idx_t'(order[i] % COLS),
                data_t'(plan[order[i] / COLS][order[i] % COLS]));
    end
  endtask

  // One random transaction. Most writes keep the matrix sorted by choosing
  // a value between the cell's neighbours (often equal to one of them);
  // a few are noise that leaves it unsorted. Searches mostly aim at stored
  // values, with near misses, arbitrary values and the range limits mixed in.
  task automatic random_item();
    int     pick;
    int     r;
    int     c;
    longint lo;
    longint hi;
    data_t  v;
    pick = $urandom_range(99);
    r    = $urandom_range(ROWS - 1);
    c    = $urandom_range(COLS - 1);
    if (pick < 30) begin
      lo = longint'(VALUE_MIN);
      hi = longint'(VALUE_MAX);
      if (r > 0 && longint'(grid[r-1][c]) > lo) lo = longint'(grid[r-1][c]);
      if (c > 0 && longint'(grid[r][c-1]) > lo) lo = longint'(grid[r][c-1]);
      if (r < ROWS - 1 && longint'(grid[r+1][c]) < hi) hi = longint'(grid[r+1][c]);
      if (c < COLS - 1 && longint'(grid[r][c+1]) < hi) hi = longint'(grid[r][c+1]);
      if (lo > hi) hi = lo;
      case ($urandom_range(3))
        0:       v = data_t'(lo);
        1:       v = data_t'(hi);
        default: v = value_between(lo, hi);
      endcase
      send_item(OP_WRITE, idx_t'(r), idx_t'(c), v);
    end else if (pick < 35) begin
      send_item(OP_WRITE, idx_t'(r), idx_t'(c), data_t'($urandom));
    end else begin
      pick = $urandom_range(99);
      if (pick < 50) begin
        v = grid[r][c];
      end else if (pick < 75) begin
        v = ($urandom_range(1) == 0) ? grid[r][c] + 1 : grid[r][c] - 1;
      end else if (pick < 85) begin
        v = data_t'($urandom);
      end else begin
        case ($urandom_range(5))
          0:       v = VALUE_MIN;
          1:       v = VALUE_MAX;
          2:       v = VALUE_MIN + 1;
          3:       v = VALUE_MAX - 1;
          4:       v = '0;
          default: v = '1;
        endcase
      end
      search_for(v);
    end
  endtask

  initial begin : stimulus
    data_t saved;
    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;

    // Phase one: the sender idles lightly and the receiver heavily. The
    // whole matrix is written first so that no search can touch an entry
    // that was never stored.
    fill_sorted(longint'(VALUE_MIN), 1 << 27, 1'b1);

    // Corners, the range limits, one interior cell and a few edge cells.
    search_for(VALUE_MIN);
    search_for(VALUE_MAX);
    search_for(grid[0][COLS-1]);
    search_for(grid[ROWS-1][0]);
    search_for(grid[7][9]);
    search_for(grid[ROWS-1][COLS-2]);
    search_for(grid[1][0]);
    search_for(grid[0][1]);
    // Values picked to be absent from the matrix.
    search_for(absent_near(grid[4][11]));
    search_for(absent_near(grid[12][3]));
    search_for(absent_near(VALUE_MIN));
    // Unsorted matrix: a tiny value in the top-right corner sends the walk
    // straight down, and a huge one in the middle disturbs the row searches.
    saved = grid[0][COLS-1];
    send_item(OP_WRITE, idx_t'(0), idx_t'(COLS - 1), VALUE_MIN);
    search_for(VALUE_MIN);
    search_for(saved);
    send_item(OP_WRITE, idx_t'(0), idx_t'(COLS - 1), saved);
    saved = grid[8][8];
    send_item(OP_WRITE, idx_t'(8), idx_t'(8), VALUE_MAX);
    search_for(VALUE_MAX);
    search_for(saved);
    search_for(grid[8][7]);
    send_item(OP_WRITE, idx_t'(8), idx_t'(8), saved);

    repeat (90) random_item();
    drain_results();

    // Phase two: idling swapped over, on the matrix left by phase one.
    tx_idle_pct = 54;
    rx_idle_pct <= 36;
    repeat (90) random_item();
    drain_results();

    // Phase three: no idling, except for one long receiver hold-off during
    // which the sender keeps offering until the block backs up.
    tx_idle_pct = 0;
    rx_idle_pct <= 0;
    hold_req    <= 1'b1;
    repeat (95) random_item();
    drain_results();

    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

// File: files.f
+incdir+src
src/smx_pkg.sv
src/smx_ram.sv
src/sorted_matrix_search.sv
dv/sorted_matrix_search_checker.sv
dv/sorted_matrix_search_tb.sv
